### src/bptc_pkg.sv
// Shared types, constants and helpers of the pressure/temperature compensation block.
`timescale 1ns / 1ps
package bptc_pkg;

   localparam int CSR_COUNT  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_T1_T2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_T3_P1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_P2_P3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_P4_P5 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_P6_P7 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_P8_P9 = 3'd5;

   localparam logic signed [33:0] FINE_OFFSET = 34'sd128000;
   localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
   localparam logic [11:0]        PRESS_SCALE = 12'd3125;
   localparam int P1_ONE_SHIFT  = 47;
   localparam int P1_NORM_SHIFT = 33;
   localparam int P4_SHIFT      = 35;

   localparam int DIV_STEPS = 64;
   localparam int MID_DEPTH = 4;
   localparam int MID_PTR_W = $clog2(MID_DEPTH);

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic signed [31:0] fine;
      logic signed [20:0] centi;
   } side_type;

   typedef struct packed {
      logic [19:0] raw_pressure;
      side_type    side;
   } temp_word_type;

   typedef struct packed {
      logic     divisor_zero;
      side_type side;
   } div_tag_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] pressure;
      logic        pressure_valid;
   } result_type;

   function automatic logic signed [20:0] centi_of(input logic signed [31:0] fine);
      logic signed [35:0] scaled;
      logic signed [27:0] shifted;
      logic signed [20:0] res;
      scaled  = (36'(fine) * 36'sd5) + 36'sd128;
      shifted = 28'(scaled >>> 8);
      if (shifted > 28'sd1048575) begin
         res = 21'sd1048575;
      end else if (shifted < -28'sd1048576) begin
         res = -21'sd1048576;
      end else begin
         res = 21'(shifted);
      end
      return res;
   endfunction

endpackage

### src/bptc_csr.sv
// Calibration register file on the APB-style port.
`timescale 1ns / 1ps
module bptc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bptc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output bptc_pkg::cal_type               cal
);
   import bptc_pkg::*;

   logic [CSR_COUNT-1:0][31:0] regs_ff;
   logic [CSR_COUNT-1:0][31:0] regs_in;
   logic [CSR_IDX_W-1:0]       idx;
   logic                       hit;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign hit        = idx < CSR_IDX_W'(CSR_COUNT);
   assign csr_pready = 1'b1;

   always_comb begin
      regs_in = regs_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         regs_in[idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = hit ? regs_ff[idx] : '0;

   always_comb begin
      cal.t1 = regs_ff[CSR_CAL_T1_T2][15:0];
      cal.t2 = regs_ff[CSR_CAL_T1_T2][31:16];
      cal.t3 = regs_ff[CSR_CAL_T3_P1][15:0];
      cal.p1 = regs_ff[CSR_CAL_T3_P1][31:16];
      cal.p2 = regs_ff[CSR_CAL_P2_P3][15:0];
      cal.p3 = regs_ff[CSR_CAL_P2_P3][31:16];
      cal.p4 = regs_ff[CSR_CAL_P4_P5][15:0];
      cal.p5 = regs_ff[CSR_CAL_P4_P5][31:16];
      cal.p6 = regs_ff[CSR_CAL_P6_P7][15:0];
      cal.p7 = regs_ff[CSR_CAL_P6_P7][31:16];
      cal.p8 = regs_ff[CSR_CAL_P8_P9][15:0];
      cal.p9 = regs_ff[CSR_CAL_P8_P9][31:16];
   end

endmodule

### src/bptc_front.sv
// Front pipeline: accepts raw words and computes fine and centi-degree temperature.
`timescale 1ns / 1ps
module bptc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [19:0]             req_raw_pressure,
   input  logic [19:0]             req_raw_temperature,
   input  bptc_pkg::cal_type       cal,
   input  logic                    mid_full,
   output logic                    mid_push,
   output bptc_pkg::temp_word_type mid_word
);
   import bptc_pkg::*;

   logic en;

   logic        a_v_ff;
   logic [19:0] a_p_ff;
   logic [19:0] a_t_ff;

   logic        b_v_ff;
   logic [19:0] b_p_ff;
   logic [31:0] b_m1_ff;
   logic [31:0] b_sq_ff;

   logic               c_v_ff;
   logic [19:0]        c_p_ff;
   logic signed [31:0] c_tv1_ff;
   logic signed [31:0] c_m2_ff;

   logic          d_v_ff;
   temp_word_type d_word_ff;

   logic signed [17:0] d1;
   logic signed [16:0] d2;
   logic signed [33:0] m1_full;
   logic signed [33:0] sq_full;
   logic signed [31:0] tv1_in;
   logic signed [19:0] sq_sh;
   logic signed [35:0] m2_full;
   logic signed [31:0] fine_in;

   assign en       = !mid_full;
   assign req_full = mid_full;
   assign mid_push = en && d_v_ff;
   assign mid_word = d_word_ff;

   always_comb begin
      d1      = $signed({1'b0, a_t_ff[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      d2      = $signed({1'b0, a_t_ff[19:4]}) - $signed({1'b0, cal.t1});
      m1_full = d1 * cal.t2;
      sq_full = d2 * d2;
      tv1_in  = $signed(b_m1_ff) >>> 11;
      sq_sh   = 20'($signed(b_sq_ff) >>> 12);
      m2_full = sq_sh * cal.t3;
      fine_in = c_tv1_ff + (c_m2_ff >>> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_push;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_p_ff                 <= req_raw_pressure;
         a_t_ff                 <= req_raw_temperature;
         b_p_ff                 <= a_p_ff;
         b_m1_ff                <= m1_full[31:0];
         b_sq_ff                <= sq_full[31:0];
         c_p_ff                 <= b_p_ff;
         c_tv1_ff               <= tv1_in;
         c_m2_ff                <= m2_full[31:0];
         d_word_ff.raw_pressure <= c_p_ff;
         d_word_ff.side.fine    <= fine_in;
         d_word_ff.side.centi   <= centi_of(fine_in);
      end
   end

endmodule

### src/bptc_mid_queue.sv
// Short queue between the temperature front and the pressure back.
`timescale 1ns / 1ps
module bptc_mid_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bptc_pkg::temp_word_type push_word,
   input  logic                    pop,
   output bptc_pkg::temp_word_type pop_word,
   output logic                    full,
   output logic                    empty
);
   import bptc_pkg::*;

   temp_word_type        mem_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0] wr_ff;
   logic [MID_PTR_W-1:0] rd_ff;
   logic [MID_PTR_W:0]   count_ff;
   logic [MID_PTR_W:0]   count_in;

   assign full     = count_ff == (MID_PTR_W+1)'(MID_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_word = mem_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule

### src/bptc_divider.sv
// Pipelined signed 64 by 31 bit divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bptc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  bptc_pkg::side_type    in_side,
   input  logic signed [63:0]    in_n,
   input  logic signed [30:0]    in_d,
   output logic                  out_valid,
   output bptc_pkg::div_tag_type out_tag,
   output logic signed [63:0]    out_quotient
);
   import bptc_pkg::*;

   logic        v_ff   [DIV_STEPS+1];
   div_tag_type tag_ff [DIV_STEPS+1];
   logic        neg_ff [DIV_STEPS+1];
   logic [30:0] mb_ff  [DIV_STEPS+1];
   logic [31:0] rem_ff [DIV_STEPS+1];
   logic [63:0] nq_ff  [DIV_STEPS+1];

   logic               fin_v_ff;
   div_tag_type        fin_tag_ff;
   logic signed [63:0] fin_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0].divisor_zero <= in_d == '0;
         tag_ff[0].side         <= in_side;
         neg_ff[0]              <= in_n[63] ^ in_d[30];
         mb_ff[0]               <= in_d[30] ? 31'(-in_d) : in_d;
         nq_ff[0]               <= in_n[63] ? 64'(-in_n) : in_n;
         rem_ff[0]              <= '0;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [31:0] shifted;
      logic [32:0] diff;

      assign shifted = {rem_ff[k-1][30:0], nq_ff[k-1][63]};
      assign diff    = {1'b0, shifted} - {2'b0, mb_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k] <= tag_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            mb_ff[k]  <= mb_ff[k-1];
            rem_ff[k] <= diff[32] ? shifted : diff[31:0];
            nq_ff[k]  <= {nq_ff[k-1][62:0], !diff[32]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (en) begin
         fin_v_ff <= v_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_tag_ff <= tag_ff[DIV_STEPS];
         fin_q_ff   <= neg_ff[DIV_STEPS] ? -$signed(nq_ff[DIV_STEPS])
                                         : $signed(nq_ff[DIV_STEPS]);
      end
   end

   assign out_valid    = fin_v_ff;
   assign out_tag      = fin_tag_ff;
   assign out_quotient = fin_q_ff;

endmodule

### src/bptc_back.sv
// Back pipeline: pressure compensation, division, correction and result queue.
`timescale 1ns / 1ps
module bptc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bptc_pkg::cal_type       cal,
   input  bptc_pkg::temp_word_type mid_word,
   input  logic                    mid_empty,
   output logic                    mid_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [31:0]      rsp_fine_temperature,
   output logic signed [20:0]      rsp_temperature_centi,
   output logic [31:0]             rsp_pressure_q24_8,
   output logic                    rsp_pressure_valid
);
   import bptc_pkg::*;

   logic en;

   // pressure coefficient stages
   logic               p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   side_type           p1_side_ff, p2_side_ff, p3_side_ff, p4_side_ff, p5_side_ff;
   logic [19:0]        p1_raw_ff, p2_raw_ff, p3_raw_ff;
   logic signed [63:0] p1_sq_ff;
   logic signed [49:0] p1_v1p5_ff, p1_v1p2_ff, p2_v1p2_ff;
   logic signed [63:0] p2_a6_ff, p2_a3_ff, p2_v2p_ff;
   logic signed [63:0] p3_v2_ff, p3_x_ff;
   logic signed [63:0] p4_y_ff, p4_t_ff;
   logic signed [63:0] p5_n_ff;
   logic signed [30:0] p5_d_ff;

   logic signed [33:0] v1;
   logic signed [67:0] sq_full;
   logic signed [49:0] v1p5, v1p2;
   logic signed [79:0] a6_full, a3_full;
   logic signed [63:0] v2p, v2_in, v1b, x_in;
   logic signed [80:0] y_full;
   logic [20:0]        pn;
   logic signed [63:0] t_in;
   logic signed [76:0] n_full;

   // divider
   logic               dv_valid;
   div_tag_type        dv_tag;
   logic signed [63:0] dv_q;

   // correction stages
   logic               q1_v_ff, q2_v_ff, q3_v_ff, q4_v_ff, q5_v_ff;
   div_tag_type        q1_tag_ff, q2_tag_ff, q3_tag_ff, q4_tag_ff, q5_tag_ff;
   logic signed [63:0] q1_p_ff, q2_p_ff, q3_p_ff;
   logic [51:0]        q1_pp0_ff;
   logic signed [51:0] q1_pp1_ff;
   logic [11:0]        q1_pp2_ff;
   logic signed [63:0] q1_b_ff, q2_b_ff, q3_b_ff;
   logic [63:0]        q2_qq_ff;
   logic signed [63:0] q3_a_ff;
   logic signed [63:0] q4_s_ff;
   logic signed [63:0] q5_r_ff;

   logic signed [50:0] q13;
   logic signed [24:0] hi;
   logic [25:0]        lo;
   logic [51:0]        pp0;
   logic signed [51:0] pp1;
   logic signed [49:0] pp2;
   logic signed [79:0] b_full, a_full;
   logic [63:0]        qq_in;

   // result queue
   result_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   result_type push_word;

   assign en      = count_ff != 2'd2;
   assign mid_pop = en && !mid_empty;

   always_comb begin
      v1      = 34'(mid_word.side.fine) - FINE_OFFSET;
      sq_full = v1 * v1;
      v1p5    = v1 * cal.p5;
      v1p2    = v1 * cal.p2;
      a6_full = p1_sq_ff * cal.p6;
      a3_full = p1_sq_ff * cal.p3;
      v2p     = (64'(p1_v1p5_ff) <<< 17) + (64'(cal.p4) <<< P4_SHIFT);
      v2_in   = p2_a6_ff + p2_v2p_ff;
      v1b     = (p2_a3_ff >>> 8) + (64'(p2_v1p2_ff) <<< 12);
      x_in    = v1b + (64'sd1 <<< P1_ONE_SHIFT);
      y_full  = p3_x_ff * $signed({1'b0, cal.p1});
      pn      = PRESS_FULL - {1'b0, p3_raw_ff};
      t_in    = $signed({43'b0, pn} << 31) - p3_v2_ff;
      n_full  = p4_t_ff * $signed({1'b0, PRESS_SCALE});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= mid_pop;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= mid_word.side;
         p1_raw_ff  <= mid_word.raw_pressure;
         p1_sq_ff   <= sq_full[63:0];
         p1_v1p5_ff <= v1p5;
         p1_v1p2_ff <= v1p2;
         p2_side_ff <= p1_side_ff;
         p2_raw_ff  <= p1_raw_ff;
         p2_a6_ff   <= a6_full[63:0];
         p2_a3_ff   <= a3_full[63:0];
         p2_v2p_ff  <= v2p;
         p2_v1p2_ff <= p1_v1p2_ff;
         p3_side_ff <= p2_side_ff;
         p3_raw_ff  <= p2_raw_ff;
         p3_v2_ff   <= v2_in;
         p3_x_ff    <= x_in;
         p4_side_ff <= p3_side_ff;
         p4_y_ff    <= y_full[63:0];
         p4_t_ff    <= t_in;
         p5_side_ff <= p4_side_ff;
         p5_n_ff    <= n_full[63:0];
         p5_d_ff    <= 31'(p4_y_ff >>> P1_NORM_SHIFT);
      end
   end

   bptc_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (p5_v_ff),
      .in_side      (p5_side_ff),
      .in_n         (p5_n_ff),
      .in_d         (p5_d_ff),
      .out_valid    (dv_valid),
      .out_tag      (dv_tag),
      .out_quotient (dv_q)
   );

   // q*q mod 2^64 from split halves of q
   always_comb begin
      q13    = 51'(dv_q >>> 13);
      hi     = q13[50:26];
      lo     = q13[25:0];
      pp0    = lo * lo;
      pp1    = hi * $signed({1'b0, lo});
      pp2    = hi * hi;
      b_full = dv_q * cal.p8;
      qq_in  = {q1_pp2_ff, 52'b0} + (64'(q1_pp1_ff) << 27) + {12'b0, q1_pp0_ff};
      a_full = $signed(q2_qq_ff) * cal.p9;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_v_ff <= 1'b0;
         q2_v_ff <= 1'b0;
         q3_v_ff <= 1'b0;
         q4_v_ff <= 1'b0;
         q5_v_ff <= 1'b0;
      end else if (en) begin
         q1_v_ff <= dv_valid;
         q2_v_ff <= q1_v_ff;
         q3_v_ff <= q2_v_ff;
         q4_v_ff <= q3_v_ff;
         q5_v_ff <= q4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_tag_ff <= dv_tag;
         q1_p_ff   <= dv_q;
         q1_pp0_ff <= pp0;
         q1_pp1_ff <= pp1;
         q1_pp2_ff <= pp2[11:0];
         q1_b_ff   <= b_full[63:0];
         q2_tag_ff <= q1_tag_ff;
         q2_p_ff   <= q1_p_ff;
         q2_qq_ff  <= qq_in;
         q2_b_ff   <= q1_b_ff >>> 19;
         q3_tag_ff <= q2_tag_ff;
         q3_p_ff   <= q2_p_ff;
         q3_a_ff   <= $signed(a_full[63:0]) >>> 25;
         q3_b_ff   <= q2_b_ff;
         q4_tag_ff <= q3_tag_ff;
         q4_s_ff   <= q3_p_ff + q3_a_ff + q3_b_ff;
         q5_tag_ff <= q4_tag_ff;
         q5_r_ff   <= (q4_s_ff >>> 8) + (64'(cal.p7) <<< 4);
      end
   end

   always_comb begin
      push_word.side           = q5_tag_ff.side;
      push_word.pressure_valid = !q5_tag_ff.divisor_zero;
      if (q5_tag_ff.divisor_zero || q5_r_ff[63]) begin
         push_word.pressure = '0;
      end else if (|q5_r_ff[62:32]) begin
         push_word.pressure = '1;
      end else begin
         push_word.pressure = q5_r_ff[31:0];
      end
   end

   assign push      = en && q5_v_ff;
   assign pop       = rsp_pop && count_ff != 2'd0;
   assign rsp_empty = count_ff == 2'd0;

   assign rsp_fine_temperature  = mem_ff[rd_ff].side.fine;
   assign rsp_temperature_centi = mem_ff[rd_ff].side.centi;
   assign rsp_pressure_q24_8    = mem_ff[rd_ff].pressure;
   assign rsp_pressure_valid    = mem_ff[rd_ff].pressure_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule

### src/baro_pressure_temperature_compensation.sv
// Top level of the pressure/temperature trimming compensation block.
// Words pass the front, mid queue, pressure stages, divider and correction to rsp.
// Throughput: one word per cycle unless stalled; the 64-stage divider sets the depth.
// A stalled output halts the back pipeline; the front keeps filling a 4-word queue.
// Reset (synchronous): clears all queues, pipeline valids and calibration registers.
`timescale 1ns / 1ps
module baro_pressure_temperature_compensation (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [19:0]                     req_raw_pressure,
   input  logic [19:0]                     req_raw_temperature,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic signed [31:0]              rsp_fine_temperature,
   output logic signed [20:0]              rsp_temperature_centi,
   output logic [31:0]                     rsp_pressure_q24_8,
   output logic                            rsp_pressure_valid,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bptc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import bptc_pkg::*;

   cal_type       cal;
   logic          mid_push, mid_pop, mid_full, mid_empty;
   temp_word_type mid_in, mid_out;

   bptc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cal         (cal)
   );

   bptc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .cal                 (cal),
      .mid_full            (mid_full),
      .mid_push            (mid_push),
      .mid_word            (mid_in)
   );

   bptc_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_word (mid_in),
      .pop       (mid_pop),
      .pop_word  (mid_out),
      .full      (mid_full),
      .empty     (mid_empty)
   );

   bptc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cal                   (cal),
      .mid_word              (mid_out),
      .mid_empty             (mid_empty),
      .mid_pop               (mid_pop),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_fine_temperature  (rsp_fine_temperature),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_pressure_valid    (rsp_pressure_valid)
   );

endmodule

### src/bptc_checker.sv
// Port-level checks of the compensation block, bound to the top level.
`timescale 1ns / 1ps
module bptc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [31:0] rsp_fine_temperature,
   input logic signed [20:0] rsp_temperature_centi,
   input logic [31:0]        rsp_pressure_q24_8,
   input logic               rsp_pressure_valid
);
   import bptc_pkg::*;

   logic signed [20:0] exp_centi;

   assign exp_centi = centi_of(rsp_fine_temperature);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pressure_valid |-> rsp_pressure_q24_8 == '0)
      else $error("pressure nonzero on zero divisor");

   a_centi_match: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_temperature_centi == exp_centi)
      else $error("centi temperature disagrees with fine temperature");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_fine_temperature))
      else $error("pending result word changed");

endmodule

bind baro_pressure_temperature_compensation bptc_checker u_bptc_checker (.*);

### bench/baro_pressure_temperature_compensation_test.sv
// Self-checking testbench for the pressure/temperature trimming compensation block.
`timescale 1ns / 1ps
module baro_pressure_temperature_compensation_test;
   import bptc_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [19:0] raw_p;
      logic [19:0] raw_t;
   } sample_type;

   typedef struct {
      logic [31:0] fine;
      logic [20:0] centi;
      logic [31:0] pres;
      logic        valid;
   } comp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [19:0] req_raw_pressure = '0;
   logic [19:0] req_raw_temperature = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [31:0] rsp_fine_temperature;
   logic signed [20:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_q24_8;
   logic rsp_pressure_valid;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   baro_pressure_temperature_compensation u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [31:0] cal_regs [CSR_COUNT];
   sample_type  pending_samples [$];
   comp_type    expected_words [$];
   int          send_hold = 0;
   int          pop_hold = 0;
   int          long_hold = 0;
   bit          no_gaps = 0;
   int          mismatches = 0;
   int          checked = 0;
   int          invalid_seen = 0;
   int          full_cycles = 0;
   int          cycles = 0;

   function automatic logic [63:0] sx16(input logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
      return $signed(x) >>> s;
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
      return $signed(x) >>> s;
   endfunction

   function automatic comp_type compensate(input logic [19:0] rp, input logic [19:0] rt);
      comp_type r;
      logic [31:0] t1, t2, t3, d1, d2, m, tv1, tv2, fine;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] v1, v2, p, a, b, q, num, ma, mb, tc;
      logic signed [63:0] tcs;
      t1 = {16'd0, cal_regs[CSR_CAL_T1_T2][15:0]};
      t2 = 32'(sx16(cal_regs[CSR_CAL_T1_T2][31:16]));
      t3 = 32'(sx16(cal_regs[CSR_CAL_T3_P1][15:0]));
      p1 = {48'd0, cal_regs[CSR_CAL_T3_P1][31:16]};
      p2 = sx16(cal_regs[CSR_CAL_P2_P3][15:0]);
      p3 = sx16(cal_regs[CSR_CAL_P2_P3][31:16]);
      p4 = sx16(cal_regs[CSR_CAL_P4_P5][15:0]);
      p5 = sx16(cal_regs[CSR_CAL_P4_P5][31:16]);
      p6 = sx16(cal_regs[CSR_CAL_P6_P7][15:0]);
      p7 = sx16(cal_regs[CSR_CAL_P6_P7][31:16]);
      p8 = sx16(cal_regs[CSR_CAL_P8_P9][15:0]);
      p9 = sx16(cal_regs[CSR_CAL_P8_P9][31:16]);
      d1 = ({12'd0, rt} >> 3) - (t1 << 1);
      m = d1 * t2;
      tv1 = asr32(m, 11);
      d2 = ({12'd0, rt} >> 4) - t1;
      m = d2 * d2;
      m = asr32(m, 12);
      m = m * t3;
      tv2 = asr32(m, 14);
      fine = tv1 + tv2;
      tc = {{32{fine[31]}}, fine} * 64'd5 + 64'd128;
      tcs = asr64(tc, 8);
      if (tcs > 64'sd1048575) tcs = 64'sd1048575;
      if (tcs < -64'sd1048576) tcs = -64'sd1048576;
      r.fine = fine;
      r.centi = tcs[20:0];
      v1 = {{32{fine[31]}}, fine} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      a = asr64(v1 * v1 * p3, 8);
      v1 = a + ((v1 * p2) << 12);
      v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
      r.pres = '0;
      r.valid = 1'b0;
      if (v1 != 0) begin
         p = 64'd1048576 - {44'd0, rp};
         num = ((p << 31) - v2) * 64'd3125;
         ma = num[63] ? -num : num;
         mb = v1[63] ? -v1 : v1;
         q = ma / mb;
         p = (num[63] != v1[63]) ? -q : q;
         q = asr64(p, 13);
         a = asr64(p9 * q * q, 25);
         b = asr64(p8 * p, 19);
         p = asr64(p + a + b, 8);
         p = p + (p7 << 4);
         if (p[63]) r.pres = '0;
         else if (p[63:32] != 0) r.pres = 32'hFFFF_FFFF;
         else r.pres = p[31:0];
         r.valid = 1'b1;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sender
   always @(negedge clock) begin
      if (reset || pending_samples.size() == 0) begin
         req_push <= 1'b0;
      end else if (send_hold > 0) begin
         send_hold--;
         req_push <= 1'b0;
      end else begin
         req_push <= 1'b1;
         req_raw_pressure <= pending_samples[0].raw_p;
         req_raw_temperature <= pending_samples[0].raw_t;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         expected_words.push_back(compensate(req_raw_pressure, req_raw_temperature));
         void'(pending_samples.pop_front());
         send_hold = no_gaps ? 0 : pick_gap();
      end
      if (req_full) full_cycles++;
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      comp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         pop_hold = no_gaps ? 0 : pick_gap();
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: fine=%0d", rsp_fine_temperature);
         end else begin
            e = expected_words.pop_front();
            checked++;
            if (!e.valid) invalid_seen++;
            if (rsp_fine_temperature !== e.fine || rsp_temperature_centi !== e.centi ||
                rsp_pressure_q24_8 !== e.pres || rsp_pressure_valid !== e.valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: fine %h/%h centi %h/%h pres %h/%h valid %b/%b (exp/got)",
                           e.fine, rsp_fine_temperature, e.centi, rsp_temperature_centi,
                           e.pres, rsp_pressure_q24_8, e.valid, rsp_pressure_valid);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cal_regs[idx] = val;
   endtask

   task automatic load_cal(input logic [31:0] c0, c1, c2, c3, c4, c5);
      csr_write(CSR_CAL_T1_T2, c0);
      csr_write(CSR_CAL_T3_P1, c1);
      csr_write(CSR_CAL_P2_P3, c2);
      csr_write(CSR_CAL_P4_P5, c3);
      csr_write(CSR_CAL_P6_P7, c4);
      csr_write(CSR_CAL_P8_P9, c5);
   endtask

   task automatic add_sample(input logic [19:0] rp, input logic [19:0] rt);
      sample_type s;
      s.raw_p = rp;
      s.raw_t = rt;
      pending_samples.push_back(s);
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || expected_words.size() != 0) @(posedge clock);
   endtask

   // typical part near nominal readings, rest across the full 20-bit range
   task automatic add_random(input int n);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            add_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
         else
            add_sample(20'($urandom_range(250000, 600000)),
                       20'($urandom_range(400000, 620000)));
      end
   endtask

   localparam logic [31:0] TYP0 = {16'd26435, 16'd27504};
   localparam logic [31:0] TYP1 = {16'd36477, 16'hFC18};
   localparam logic [31:0] TYP2 = {16'd3024, 16'hD643};
   localparam logic [31:0] TYP3 = {16'd140, 16'd2855};
   localparam logic [31:0] TYP4 = {16'd15500, 16'hFFF9};
   localparam logic [31:0] TYP5 = {16'd6000, 16'hC6F8};

   initial begin
      for (int i = 0; i < CSR_COUNT; i++) cal_regs[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers at reset: zero P1 gives a zero divisor
      add_sample(20'd0, 20'd0);
      add_sample(20'hFFFFF, 20'hFFFFF);
      add_sample(20'd415148, 20'd519888);
      wait_idle();

      // directed: nominal calibration, field extremes and single bits
      load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, TYP5);
      add_sample(20'd415148, 20'd519888);
      add_sample(20'd0, 20'd0);
      add_sample(20'hFFFFF, 20'hFFFFF);
      add_sample(20'd0, 20'hFFFFF);
      add_sample(20'hFFFFF, 20'd0);
      add_sample(20'h80000, 20'h80000);
      add_sample(20'h7FFFF, 20'h7FFFF);
      add_sample(20'h55555, 20'hAAAAA);
      add_sample(20'hAAAAA, 20'h55555);
      for (int b = 0; b < 20; b += 4) add_sample(20'd1 << b, 20'd1 << (19 - b));
      wait_idle();

      // one long receiver hold-off with the sender flooding, no gaps
      no_gaps = 1;
      long_hold = 400;
      add_random(200);
      wait_idle();
      no_gaps = 0;

      add_random(300);
      wait_idle();

      // extremes of the calibration words
      load_cal(32'h7FFF_FFFF, 32'hFFFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
               32'h7FFF_7FFF, 32'h7FFF_7FFF);
      add_random(200);
      wait_idle();
      load_cal(32'h8000_0000, 32'h0001_8000, 32'h8000_8000, 32'h8000_8000,
               32'h8000_8000, 32'h8000_8000);
      add_random(200);
      wait_idle();
      load_cal('1, '1, '1, '1, '1, '1);
      add_random(200);
      wait_idle();

      // random calibrations: some with a zero P1
      repeat (4) begin
         load_cal($urandom, $urandom & ($urandom_range(0, 3) == 0 ? 32'h0000_FFFF : '1),
                  $urandom, $urandom, $urandom, $urandom);
         add_random(130);
         wait_idle();
      end
      load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, TYP5);
      add_random(300);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d words (%0d without pressure), input stalled %0d cycles",
               checked, invalid_seen, full_cycles);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
